FILE: hdl/unsorted_array_priority_queue_assert.svh
// Assertion macros used by the checker file of the priority queue.
// Depends on nothing; include it by its bare file name.
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UAPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("uapq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UAPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("uapq assertion failed");

`endif

FILE: hdl/uapq_pkg.sv
// Package of the unsorted array priority queue: sizes, codes, state and result types.
// Depends on nothing; the top level, the sequencer and the checker import it.
`default_nettype none

package uapq_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 2 * DATA_W;
    localparam int CMD_W       = 2;
    localparam int STS_W       = 2;
    localparam int COUNT_OUT_W = 11;
    localparam int IN_TDATA_W  = ((2 * DATA_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 2 * DATA_W + COUNT_OUT_W + 2;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_LAST,
        S_WB,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [STS_W-1:0]       status;
        logic [DATA_W-1:0]      value;
        logic [DATA_W-1:0]      prio;
        logic [COUNT_OUT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } t_result;

    // Low bits of the entry count as they appear in the result field.
    function automatic logic [COUNT_OUT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_OUT_W-1:0] wide;
        wide = {{COUNT_OUT_W{1'b0}}, c};
        return wide[COUNT_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/unsorted_array_priority_queue.sv
// Top level of the unsorted array priority queue: stream ports, entry RAM, sequencer
// and output register. Depends on uapq_pkg, uapq_ram and uapq_ctrl.
//
// Use: each input beat on the s_axis channel carries one command in s_axis_tuser
// (enqueue, dequeue of the highest priority, or query) and a value and priority in
// s_axis_tdata. Every command yields exactly one beat on m_axis: a status code in
// m_axis_tuser and the removed value and priority, the entry count after the command
// and the full and empty flags in m_axis_tdata. Ties on priority go to the larger value;
// priorities and values are compared as signed numbers. Commands are handled one at a
// time. An enqueue or a query passes from the idle state through the execute state to
// the result state; a dequeue reads every stored entry once through the single read
// port of the entry RAM in the scan state, then passes through the last-read and
// write-back states to the result state. The next beat is taken once the sequencer is
// back in its idle state. The removed slot is refilled with the last stored entry. The
// result sits in an output register, so the next command is accepted while the
// previous result still waits for m_axis_tready; a stalled result holds its beat, and
// the block only stops once a second result is ready behind it. A synchronous
// active-low reset empties the queue at once; no clearing pass runs, because only
// entries below the count are ever read.
`default_nettype none

module unsorted_array_priority_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0 up: item_value[31:0], item_priority[63:32].
    input  wire logic [uapq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0 up: command[1:0].
    input  wire logic [uapq_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // Fields from bit 0 up: out_value[31:0], out_priority[63:32], entry_count[74:64],
    // is_full[75], is_empty[76], zero fill above.
    output logic [uapq_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // Fields from bit 0 up: status[1:0].
    output logic [uapq_pkg::STS_W-1:0]             m_axis_tuser
);
    import uapq_pkg::*;

    logic              res_valid, res_ready;
    t_result           res;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;

    logic              r_out_valid;
    t_result           r_out;
    logic              out_load;

    // Value and priority of each entry share one RAM word, priority on top.
    uapq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    uapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_value     (s_axis_tdata[DATA_W-1:0]),
        .i_prio      (s_axis_tdata[ENTRY_W-1:DATA_W]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !r_out_valid || m_axis_tready;
    assign out_load  = res_valid && res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.empty, r_out.full, r_out.count,
                                         r_out.prio, r_out.value});

endmodule

`default_nettype wire

FILE: hdl/uapq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module uapq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/uapq_ctrl.sv
// Sequencer of the priority queue: command decode, entry count, scan for the best
// entry and write-back of the removal. Depends on uapq_pkg; drives the entry RAM.
`default_nettype none

module uapq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [uapq_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [uapq_pkg::DATA_W-1:0]   i_value,
    input  wire logic [uapq_pkg::DATA_W-1:0]   i_prio,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output uapq_pkg::t_result                  o_res,
    output logic                               o_wr_en,
    output logic [uapq_pkg::ADDR_W-1:0]        o_wr_addr,
    output logic [uapq_pkg::ENTRY_W-1:0]       o_wr_data,
    output logic                               o_rd_en,
    output logic [uapq_pkg::ADDR_W-1:0]        o_rd_addr,
    input  wire logic [uapq_pkg::ENTRY_W-1:0]  i_rd_data
);
    import uapq_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_rd_pending;
    logic [CMD_W-1:0]    r_cmd;
    logic [DATA_W-1:0]   r_val, r_pri;
    logic [STS_W-1:0]    r_status, n_status;
    logic [ADDR_W-1:0]   r_addr, r_rd_addr, r_best_idx;
    logic [DATA_W-1:0]   r_best_val, r_best_pri;

    logic                in_accept;
    logic                is_full, is_empty;
    logic [CNT_W-1:0]    last_cnt;
    logic                scan_end;
    logic [DATA_W-1:0]   rd_val, rd_pri;
    logic                take;

    assign in_accept = i_in_valid && o_in_ready;
    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign last_cnt  = r_count - CNT_W'(1);
    assign scan_end  = (r_addr == last_cnt[ADDR_W-1:0]);
    assign rd_val    = i_rd_data[DATA_W-1:0];
    assign rd_pri    = i_rd_data[ENTRY_W-1:DATA_W];

    // The first entry seeds the running best; later ones replace it on a larger
    // priority, or on an equal priority with a larger value.
    assign take = (r_rd_addr == '0)
               || ($signed(rd_pri) > $signed(r_best_pri))
               || ((rd_pri == r_best_pri) && ($signed(rd_val) > $signed(r_best_val)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_DEQUEUE && !is_empty) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_status = STS_OK;
        case (r_cmd)
            CMD_ENQUEUE: begin
                if (is_full) begin
                    n_status = STS_FULL;
                end
            end
            CMD_DEQUEUE: begin
                if (is_empty) begin
                    n_status = STS_EMPTY;
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
        if (r_state == S_EXEC && r_cmd == CMD_ENQUEUE && !is_full) begin
            n_count = r_count + CNT_W'(1);
        end else if (r_state == S_WB) begin
            n_count = last_cnt;
        end
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_rd_en     = (r_state == S_SCAN);
        o_rd_addr   = r_addr;
        o_res_valid = (r_state == S_RESULT);
        o_wr_en     = 1'b0;
        o_wr_addr   = r_count[ADDR_W-1:0];
        o_wr_data   = {r_pri, r_val};
        if (r_state == S_EXEC && r_cmd == CMD_ENQUEUE && !is_full) begin
            o_wr_en = 1'b1;
        end else if (r_state == S_WB) begin
            // The read data register still holds the last entry, which fills the hole.
            o_wr_en   = 1'b1;
            o_wr_addr = r_best_idx;
            o_wr_data = i_rd_data;
        end
        o_res.status = r_status;
        o_res.value  = r_best_val;
        o_res.prio   = r_best_pri;
        o_res.count  = count_field(r_count);
        o_res.full   = is_full;
        o_res.empty  = is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rd_pending <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rd_pending <= o_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_cmd;
            r_val <= i_value;
            r_pri <= i_prio;
        end
        if (r_state == S_EXEC) begin
            r_status   <= n_status;
            r_addr     <= '0;
            r_best_val <= '0;
            r_best_pri <= '0;
        end
        if (o_rd_en) begin
            r_addr    <= r_addr + ADDR_W'(1);
            r_rd_addr <= r_addr;
        end
        if (r_rd_pending && take) begin
            r_best_idx <= r_rd_addr;
            r_best_val <= rd_val;
            r_best_pri <= rd_pri;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/uapq_check.sv
// Port-level checker of the priority queue and its bind to the top level.
// Depends on uapq_pkg and the assertion macros in unsorted_array_priority_queue_assert.svh.
`default_nettype none
`include "unsorted_array_priority_queue_assert.svh"

module uapq_check (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [uapq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic [uapq_pkg::CMD_W-1:0]        s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [uapq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic [uapq_pkg::STS_W-1:0]        m_axis_tuser
);
    import uapq_pkg::*;

    logic out_full, out_empty;
    logic in_beat;

    assign out_full  = m_axis_tdata[2*DATA_W+COUNT_OUT_W];
    assign out_empty = m_axis_tdata[2*DATA_W+COUNT_OUT_W+1];
    assign in_beat   = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || 1'b1);

    // A stalled result beat holds its payload.
    `UAPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A refused enqueue reports a full store and no removed entry.
    `UAPQ_ASSERT_NOW(a_full_refused, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == STS_FULL, out_full && m_axis_tdata[2*DATA_W-1:0] == '0)

    // A refused dequeue reports an empty store with a zero count.
    `UAPQ_ASSERT_NOW(a_empty_refused, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == STS_EMPTY, out_empty && m_axis_tdata[2*DATA_W+COUNT_OUT_W-1:2*DATA_W] == '0)

    // The store cannot be full and empty at once.
    `UAPQ_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid, !(out_full && out_empty))

    // Commands are taken one at a time, so two input beats never come back to back.
    `UAPQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_beat, !s_axis_tready)

endmodule

bind unsorted_array_priority_queue uapq_check u_uapq_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
